/* sv/ljp_pkg.sv */
// Shared types, constants and helpers for the Lennard-Jones pair energy pipeline.
// Used by every module of lj_pair_energy_min_image; no dependencies.
package ljp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ENERGY_FRAC = 24;
    localparam int ESHIFT      = 30 + FRAC_BITS - ENERGY_FRAC;
    localparam int SQRT_CELLS  = 32;
    localparam int DIV_CELLS   = 64;

    localparam logic [31:0] BOX_RESET = 32'(10) << FRAC_BITS;
    localparam logic [31:0] EPS_RESET = 32'(1) << FRAC_BITS;
    localparam logic [31:0] SIG_RESET = 32'(1) << FRAC_BITS;

    localparam logic [47:0] ENERGY_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [63:0] ENERGY_MAX_W = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] ENERGY_NEG_W = 64'h0000_8000_0000_0000;

    typedef enum logic [1:0] {
        REG_BOX_LENGTH     = 2'd0,
        REG_WELL_DEPTH     = 2'd1,
        REG_CONTACT_RADIUS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic        v;
        logic        flag;
        logic [31:0] distance;
    } tag_t;

    typedef struct packed {
        logic        v;
        logic        flag;
        logic        clip;
        logic        neg;
        logic [31:0] distance;
        logic [63:0] q;
        logic [63:0] r;
    } side_t;

    typedef struct packed {
        logic        saturated;
        logic [47:0] energy;
        logic [31:0] distance;
    } res_t;

    function automatic logic [63:0] q32_sel(input logic [127:0] p);
        return (p[127:96] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[95:32];
    endfunction

    function automatic logic q32_clip(input logic [127:0] p);
        return p[127:96] != 32'd0;
    endfunction

endpackage

/* sv/ljp_sqrt_cell.sv */
// One digit cell of the square-root chain: one result bit per cell.
// Depends on ljp_pkg.
module ljp_sqrt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [63:0]    rad_in,
    input  logic [33:0]    rem_in,
    input  logic [31:0]    root_in,
    input  ljp_pkg::tag_t  tag_in,
    output logic [63:0]    rad_reg,
    output logic [33:0]    rem_reg,
    output logic [31:0]    root_reg,
    output ljp_pkg::tag_t  tag_reg
);
    import ljp_pkg::*;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    always_comb begin
        rem_sh = {rem_in[32:0], rad_in[63:62]};
        trial  = {1'b0, root_in, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.v <= 1'b0;
        end else if (en) begin
            tag_reg  <= tag_in;
            rad_reg  <= {rad_in[61:0], 2'b00};
            rem_reg  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_reg <= {root_in[30:0], ge};
        end
    end

endmodule

/* sv/ljp_div_cell.sv */
// One restoring-division cell: one quotient bit per cell.
// Depends on ljp_pkg.
module ljp_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [31:0]    rem_in,
    input  logic [63:0]    dq_in,
    input  ljp_pkg::tag_t  tag_in,
    output logic [31:0]    rem_reg,
    output logic [63:0]    dq_reg,
    output ljp_pkg::tag_t  tag_reg
);
    import ljp_pkg::*;

    logic [32:0] rem2;
    logic        ge;

    always_comb begin
        rem2 = {rem_in, dq_in[63]};
        ge   = rem2 >= {1'b0, tag_in.distance};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.v <= 1'b0;
        end else if (en) begin
            tag_reg <= tag_in;
            rem_reg <= ge ? 32'(rem2 - {1'b0, tag_in.distance}) : rem2[31:0];
            dq_reg  <= {dq_in[62:0], ge};
        end
    end

endmodule

/* sv/ljp_mul_stage.sv */
// 64x64 multiply as four 32x32 partial products over two registered steps.
// Carries the power-chain sideband alongside. Depends on ljp_pkg.
module ljp_mul_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic [63:0]     a,
    input  logic [63:0]     b,
    input  ljp_pkg::side_t  side_in,
    output logic [127:0]    prod_reg,
    output ljp_pkg::side_t  side_reg
);
    import ljp_pkg::*;

    logic [63:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    side_t       side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg.v <= 1'b0;
            side_reg.v  <= 1'b0;
        end else if (en) begin
            pp00_reg  <= a[31:0]  * b[31:0];
            pp01_reg  <= a[31:0]  * b[63:32];
            pp10_reg  <= a[63:32] * b[31:0];
            pp11_reg  <= a[63:32] * b[63:32];
            side1_reg <= side_in;
            prod_reg  <= {pp11_reg, 64'd0} + {32'd0, pp01_reg, 32'd0}
                       + {32'd0, pp10_reg, 32'd0} + {64'd0, pp00_reg};
            side_reg  <= side1_reg;
        end
    end

endmodule

/* sv/lj_pair_energy_min_image.sv */
// Top level: minimum-image Lennard-Jones 12-6 pair energy pipeline.
// Depends on ljp_pkg, ljp_sqrt_cell, ljp_div_cell, ljp_mul_stage.
//
//  channel  | direction | width               | contents
//  s_       | in        | tdata 192           | pair positions
//  m_       | out       | tdata 80, tuser 1   | distance, energy, saturated
//  cfg_     | in        | index 2, data 32    | register write
//
// One pair per cycle sustained unless the full output buffer holds the chain. Stages: 3 front
// stages, 32 square-root cells, 64 divider cells, five multipliers, 1 output buffer.
// The 64-cell divider chain sets the latency. Reset is synchronous, active low.
// A 2-entry output buffer absorbs stalls; the whole chain holds only when it is full.
module lj_pair_energy_min_image (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pair_distance, pair_energy
    output logic [79:0]  m_tdata,
    // saturated
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import ljp_pkg::*;

    logic [31:0] box_reg, eps_reg, sig_reg;
    logic        en;

    // configuration
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= BOX_RESET;
            eps_reg <= EPS_RESET;
            sig_reg <= SIG_RESET;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_BOX_LENGTH:     box_reg <= cfg_data;
                REG_WELL_DEPTH:     eps_reg <= cfg_data;
                REG_CONTACT_RADIUS: sig_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: wrap, square, sum
    logic [31:0]       mag_next [3];
    logic [31:0]       mag_reg  [3];
    logic [63:0]       sq_reg   [3];
    logic [63:0]       sum_reg;
    logic              sovf_reg;
    logic              va_reg, vb_reg, vc_reg;
    logic signed [34:0] d, d2, boxs, w;
    logic [65:0]       sum3;

    always_comb begin
        boxs = $signed({3'b000, box_reg});
        for (int i = 0; i < 3; i++) begin
            d  = 35'($signed(s_tdata[32*i +: 32])) - 35'($signed(s_tdata[32*(i+3) +: 32]));
            d2 = d <<< 1;
            if (d2 > boxs)       w = d - boxs;
            else if (d2 < -boxs) w = d + boxs;
            else                 w = d;
            mag_next[i] = w[34] ? 32'(-w) : w[31:0];
        end
        sum3 = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= mag_next[i];
                sq_reg[i]  <= mag_reg[i] * mag_reg[i];
            end
            sum_reg  <= sum3[63:0];
            sovf_reg <= sum3[65:64] != 2'b00;
        end
    end

    // square-root chain
    logic [63:0] rad [SQRT_CELLS+1];
    logic [33:0] rem [SQRT_CELLS+1];
    logic [31:0] root[SQRT_CELLS+1];
    tag_t        stag[SQRT_CELLS+1];

    assign rad[0]  = sum_reg;
    assign rem[0]  = 34'd0;
    assign root[0] = 32'd0;
    assign stag[0] = '{v: vc_reg, flag: sovf_reg, distance: 32'd0};

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        ljp_sqrt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .rad_in(rad[g]), .rem_in(rem[g]), .root_in(root[g]), .tag_in(stag[g]),
            .rad_reg(rad[g+1]), .rem_reg(rem[g+1]), .root_reg(root[g+1]),
            .tag_reg(stag[g+1])
        );
    end

    // divider chain: q = (sigma << 32) / distance
    logic [31:0] drem[DIV_CELLS+1];
    logic [63:0] dq  [DIV_CELLS+1];
    tag_t        dtag[DIV_CELLS+1];

    assign drem[0] = 32'd0;
    assign dq[0]   = {sig_reg, 32'd0};
    assign dtag[0] = '{v: stag[SQRT_CELLS].v, flag: stag[SQRT_CELLS].flag,
                       distance: stag[SQRT_CELLS].flag ? 32'hFFFF_FFFF
                                                       : root[SQRT_CELLS]};

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        ljp_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .rem_in(drem[g]), .dq_in(dq[g]), .tag_in(dtag[g]),
            .rem_reg(drem[g+1]), .dq_reg(dq[g+1]), .tag_reg(dtag[g+1])
        );
    end

    // power chain q^2, q^3, q^6, q^12, then eps * |q^12 - q^6|
    logic [63:0]  ma [5];
    logic [63:0]  mb [5];
    side_t        sin [5];
    side_t        sout[5];
    logic [127:0] prod[5];
    logic [63:0]  q12, diff;
    logic         neg;

    always_comb begin
        sin[0] = '{v: dtag[DIV_CELLS].v, flag: dtag[DIV_CELLS].flag, clip: 1'b0,
                   neg: 1'b0, distance: dtag[DIV_CELLS].distance, q: dq[DIV_CELLS],
                   r: 64'd0};
        ma[0] = dq[DIV_CELLS];
        mb[0] = dq[DIV_CELLS];

        sin[1]      = sout[0];
        sin[1].clip = sout[0].clip | q32_clip(prod[0]);
        ma[1]       = q32_sel(prod[0]);
        mb[1]       = sout[0].q;

        sin[2]      = sout[1];
        sin[2].clip = sout[1].clip | q32_clip(prod[1]);
        ma[2]       = q32_sel(prod[1]);
        mb[2]       = q32_sel(prod[1]);

        sin[3]      = sout[2];
        sin[3].clip = sout[2].clip | q32_clip(prod[2]);
        sin[3].r    = q32_sel(prod[2]);
        ma[3]       = q32_sel(prod[2]);
        mb[3]       = q32_sel(prod[2]);

        q12         = q32_sel(prod[3]);
        neg         = q12 < sout[3].r;
        diff        = neg ? sout[3].r - q12 : q12 - sout[3].r;
        sin[4]      = sout[3];
        sin[4].clip = sout[3].clip | q32_clip(prod[3]);
        sin[4].neg  = neg;
        ma[4]       = {32'd0, eps_reg};
        mb[4]       = diff;
    end

    for (genvar g = 0; g < 5; g++) begin : g_mul
        ljp_mul_stage u_mul (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .a(ma[g]), .b(mb[g]), .side_in(sin[g]),
            .prod_reg(prod[g]), .side_reg(sout[g])
        );
    end

    // final energy select
    logic [63:0] emag;
    logic        eclip;
    res_t        res;

    always_comb begin
        emag  = prod[4][ESHIFT +: 64];
        eclip = prod[4][127:ESHIFT+64] != '0;
        res.distance  = sout[4].distance;
        res.saturated = sout[4].flag;
        res.energy    = 48'd0;
        if (sout[4].distance == 32'd0) begin
            res.energy    = ENERGY_MAX;
            res.saturated = 1'b1;
        end else if (eps_reg == 32'd0) begin
            res.energy = 48'd0;
        end else if (sout[4].clip) begin
            res.energy    = ENERGY_MAX;
            res.saturated = 1'b1;
        end else if (sout[4].neg) begin
            if (eclip || emag > ENERGY_NEG_W) begin
                res.energy    = ENERGY_NEG_W[47:0];
                res.saturated = 1'b1;
            end else begin
                res.energy = 48'd0 - emag[47:0];
            end
        end else begin
            if (eclip || emag > ENERGY_MAX_W) begin
                res.energy    = ENERGY_MAX;
                res.saturated = 1'b1;
            end else begin
                res.energy = emag[47:0];
            end
        end
    end

    // output buffer
    res_t       out0_reg, out1_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign en       = !(sout[4].v && cnt_reg == 2'd2);
    assign s_tready = en;
    assign push     = sout[4].v && en;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {out0_reg.energy, out0_reg.distance};
    assign m_tuser  = out0_reg.saturated;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            if (push && !pop) begin
                if (cnt_reg == 2'd0) out0_reg <= res;
                else                 out1_reg <= res;
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                out0_reg <= out1_reg;
                cnt_reg  <= cnt_reg - 2'd1;
            end else if (pop && push) begin
                out0_reg <= res;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("output buffer count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && cnt_reg == 2'd2)) else $error("push into full output buffer");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("pop did not free an entry");
    a_zero_dist_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[31:0] == 32'd0) |-> m_tuser)
        else $error("zero distance without saturation flag");

endmodule

/* sim/lj_pair_energy_min_image_tb.sv */
// Self-checking testbench for lj_pair_energy_min_image: pair positions in, distance/energy out.
// Predicts every result with its own fixed-point model; depends on ljp_pkg and the DUT only.
`timescale 1ns / 1ps

module lj_pair_energy_min_image_tb;
    import ljp_pkg::*;

    typedef struct packed {
        logic [31:0] distance;
        logic [47:0] energy;
        logic        sat;
    } pair_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = REG_BOX_LENGTH;
    logic [31:0]  cfg_data = '0;

    logic [31:0]  box_len, eps, sigma;
    pair_result_t energy_queue[$];
    int           n_errors = 0;
    int           n_results = 0;
    bit           quiet_mode = 1'b0;
    bit           hold_off = 1'b0;

    lj_pair_energy_min_image i_dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [33:0] wrapped_delta(logic [31:0] a, logic [31:0] b);
        logic signed [33:0] d;
        logic signed [34:0] box;
        d = 34'(signed'(a)) - 34'(signed'(b));
        box = 35'({1'b0, box_len});
        if (2 * 35'(d) > box)
            d = d - 34'(box);
        else if (2 * 35'(d) < -box)
            d = d + 34'(box);
        return d;
    endfunction

    function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b, ref bit clip);
        logic [127:0] p;
        p = a * b;
        if (p[127:96] != 0) begin
            clip = 1'b1;
            return '1;
        end
        return p[95:32];
    endfunction

    function automatic pair_result_t lj_energy(logic [191:0] pos);
        pair_result_t       r;
        logic signed [33:0] d;
        logic [65:0]        sum;
        logic [63:0]        m, n, root, q, q2, q3, q6, q12, diff, mag, bitv;
        logic [127:0]       p;
        bit                 clip, neg;
        sum = 0;
        clip = 0;
        r.sat = 0;
        for (int i = 0; i < 3; i++) begin
            d = wrapped_delta(pos[32*i +: 32], pos[32*(i+3) +: 32]);
            m = 64'(d < 0 ? -d : d);
            sum = sum + 66'(m * m);
        end
        if (sum[65:64] != 0) begin
            r.distance = '1;
            r.sat = 1;
        end else begin
            n = sum[63:0];
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            r.distance = root[31:0];
        end
        if (r.distance == 0) begin
            r.energy = ENERGY_MAX;
            r.sat = 1;
        end else if (eps == 0) begin
            r.energy = 0;
        end else begin
            q = {sigma, 32'd0} / 64'(r.distance);
            q2 = q32_mul(q, q, clip);
            q3 = q32_mul(q2, q, clip);
            q6 = q32_mul(q3, q3, clip);
            q12 = q32_mul(q6, q6, clip);
            if (clip) begin
                r.energy = ENERGY_MAX;
                r.sat = 1;
            end else begin
                neg = q12 < q6;
                diff = neg ? q6 - q12 : q12 - q6;
                p = 128'(eps) * 128'(diff);
                p = p >> (30 + FRAC_BITS - ENERGY_FRAC);
                if (neg) begin
                    if (p > 128'h8000_0000_0000) begin
                        p = 128'h8000_0000_0000;
                        r.sat = 1;
                    end
                    mag = p[63:0];
                    r.energy = 48'(-mag);
                end else begin
                    if (p > 128'h7FFF_FFFF_FFFF) begin
                        p = 128'h7FFF_FFFF_FFFF;
                        r.sat = 1;
                    end
                    r.energy = p[47:0];
                end
            end
        end
        return r;
    endfunction

    task automatic send_pair(logic [191:0] pos);
        int gap;
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        energy_queue.push_back(lj_energy(pos));
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BOX_LENGTH:     box_len = value;
            REG_WELL_DEPTH:     eps = value;
            REG_CONTACT_RADIUS: sigma = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        int guard;
        idle_input();
        guard = 0;
        while (energy_queue.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (120) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h000A_0000));
            2: return -32'($urandom_range(0, 32'h000A_0000));
            3: return 32'($urandom_range(0, 32'h0003_0000));
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    function automatic logic [191:0] near_pair();
        logic [191:0] pos;
        for (int i = 0; i < 3; i++) begin
            pos[32*i +: 32] = rand_coord();
            pos[32*(i+3) +: 32] = pos[32*i +: 32] + 32'(signed'(17'($urandom())));
        end
        return pos;
    endfunction

    function automatic logic [191:0] random_pair();
        logic [191:0] pos;
        for (int i = 0; i < 6; i++) pos[32*i +: 32] = rand_coord();
        return pos;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", n_results, what, got, want);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        pair_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (energy_queue.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(m_tdata), 0);
            end else begin
                want = energy_queue.pop_front();
                if (m_tdata[31:0] != want.distance)
                    report_mismatch("pair_distance", 64'(m_tdata[31:0]), 64'(want.distance));
                if (m_tdata[79:32] != want.energy)
                    report_mismatch("pair_energy", 64'(m_tdata[79:32]), 64'(want.energy));
                if (m_tuser != want.sat)
                    report_mismatch("saturated", 64'(m_tuser), 64'(want.sat));
            end
            n_results++;
        end
    end

    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        logic [31:0] c;
        send_pair('0);
        send_pair({6{32'h7FFF_FFFF}});
        send_pair({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_pair({96'd0, 32'h0001_0000, 64'd0});
        send_pair({96'd0, 32'h0001_1F00, 64'd0});
        send_pair({96'd0, 32'h0000_0100, 64'd0});
        send_pair({96'd0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
        send_pair({96'd0, 32'h0005_0000, 64'd0});
        send_pair({96'd0, 32'h0005_0001, 64'd0});
        send_pair({96'd0, 32'hFFFB_0000, 64'd0});
        send_pair({96'd0, 32'hFFFA_FFFF, 64'd0});
        send_pair({96'd0, 32'h0003_0000, 32'h0004_0000, 32'h0000_C000});
        for (int i = 0; i < 8; i++) begin
            c = $urandom();
            send_pair({6{c}} ^ {32'd0, 32'd0, 32'h0001_0000, 96'd0});
        end
        drain();
    endtask

    task automatic test_register_settings();
        logic [31:0] boxes[4] = '{32'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0010_0000};
        logic [31:0] epss[4]  = '{32'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0002_8000};
        logic [31:0] sigs[4]  = '{32'd0, 32'hFFFF_FFFF, 32'h0000_0100, 32'h0001_8000};
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_BOX_LENGTH, boxes[k]);
            write_reg(REG_WELL_DEPTH, epss[k]);
            write_reg(REG_CONTACT_RADIUS, sigs[k]);
            for (int i = 0; i < 60; i++) send_pair(($urandom_range(0, 1)) ? near_pair() : random_pair());
            drain();
        end
        write_reg(REG_BOX_LENGTH, BOX_RESET);
        write_reg(REG_WELL_DEPTH, EPS_RESET);
        write_reg(REG_CONTACT_RADIUS, SIG_RESET);
    endtask

    task automatic test_random_pairs();
        for (int k = 0; k < 6; k++) begin
            write_reg(REG_BOX_LENGTH, $urandom_range(0, 3) == 0 ? $urandom() :
                      32'($urandom_range(1, 32'h0020_0000)));
            write_reg(REG_WELL_DEPTH, $urandom_range(0, 3) == 0 ? $urandom() :
                      32'($urandom_range(1, 32'h0004_0000)));
            write_reg(REG_CONTACT_RADIUS, $urandom_range(0, 3) == 0 ? $urandom() :
                      32'($urandom_range(32'h0000_4000, 32'h0002_0000)));
            for (int i = 0; i < 180; i++)
                send_pair($urandom_range(0, 3) != 0 ? near_pair() : random_pair());
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 250; i++) send_pair(near_pair());
        join
        drain();
    endtask

    task automatic test_full_rate();
        quiet_mode = 1'b1;
        for (int i = 0; i < 200; i++) send_pair(near_pair());
        drain();
    endtask

    initial begin
        box_len = BOX_RESET;
        eps = EPS_RESET;
        sigma = SIG_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_settings();
        test_random_pairs();
        test_backpressure();
        test_full_rate();
        if (n_errors == 0 && energy_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
